>>> design/first_fit_heap_allocator_macros.svh
// ----------------------------------------------------------------------------
// First-fit heap allocator assertion macros
// Short forms for the concurrent checks used by the allocator modules.
// ----------------------------------------------------------------------------
// Both macros sample on clk_i and stay quiet while rst_ni is low.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH

// General property check.
`define FFH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Same-cycle implication check.
`define FFH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> design/ffh_pkg.sv
// ----------------------------------------------------------------------------
// First-fit heap allocator package
// Sizes, codes and the control bundles shared by the cells, scan and top.
// ----------------------------------------------------------------------------
`default_nettype none

package ffh_pkg;

  // Segment table depth.
  localparam int MAX_SEGMENTS = 256;
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);

  // Field widths.
  localparam int SEG_W     = 24;
  localparam int ADDR_W    = 32;
  localparam int REQ_W     = 25;
  localparam int NEED_W    = REQ_W + 1;
  localparam int HSIZE_W   = 25;
  localparam int HDR_W     = 7;
  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  // Group size of the first-fit scan.
  localparam int GRP_SIZE = 16;
  localparam int NUM_GRP  = (MAX_SEGMENTS + GRP_SIZE - 1) / GRP_SIZE;
  localparam int PAD_W    = NUM_GRP * GRP_SIZE;

  // Heap limit and reset values of the registers.
  localparam logic [HSIZE_W-1:0] HEAP_LIMIT       = 25'h100_0000;
  localparam logic [ADDR_W-1:0]  RESET_HEAP_BASE  = 32'h0010_0000;
  localparam logic [HSIZE_W-1:0] RESET_HEAP_SIZE  = 25'h010_0000;
  localparam logic [HDR_W-1:0]   RESET_HEADER     = 7'd12;
  localparam logic [SEG_W-1:0]   RESET_SEG_SIZE   = 24'h10_0000 - 24'd12;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_REINIT  = 2'd2
  } ffh_op_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_GRANTED  = 3'd0,
    STS_NO_MEM   = 3'd1,
    STS_RELEASED = 3'd2,
    STS_IGNORED  = 3'd3,
    STS_UNKNOWN  = 3'd4
  } ffh_status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEAP_BASE    = 2'd0,
    CFG_HEAP_SIZE    = 2'd1,
    CFG_HEADER_BYTES = 2'd2
  } ffh_cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_GROUP,
    ST_SELECT,
    ST_APPLY
  } ffh_state_e;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_ALLOC,
    MODE_RELEASE
  } ffh_mode_e;

  // Broadcast to every cell in the compare cycle.
  typedef struct packed {
    logic                  en;
    ffh_mode_e             mode;
    logic [NEED_W-1:0]     need;
    logic [ADDR_W-1:0]     target;
  } ffh_match_t;

  // Broadcast to every cell in the update cycle.
  typedef struct packed {
    logic              alloc;
    logic              release_seg;
    logic              reinit;
    logic              split;
    logic [SEG_W-1:0]  need;
    logic [SEG_W-1:0]  new_start;
    logic [SEG_W-1:0]  new_size;
    logic [SEG_W-1:0]  init_size;
  } ffh_upd_t;

endpackage

`default_nettype wire

>>> design/ffh_cell.sv
// ----------------------------------------------------------------------------
// First-fit heap allocator table cell
// Holds one segment entry, compares it against the current request and
// shifts in its left neighbor's entry when a split opens a slot.
// ----------------------------------------------------------------------------
`default_nettype none

module ffh_cell (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     valid_i,
  input  wire ffh_pkg::ffh_match_t      match_i,
  input  wire ffh_pkg::ffh_upd_t        upd_i,
  input  wire logic                     at_i,
  input  wire logic                     left_at_i,
  input  wire logic                     left_win_i,
  input  wire logic [ffh_pkg::SEG_W-1:0] left_start_i,
  input  wire logic [ffh_pkg::SEG_W-1:0] left_size_i,
  input  wire logic                     left_free_i,
  output logic                          hit_o,
  output logic                          win_o,
  output logic [ffh_pkg::SEG_W-1:0]     start_o,
  output logic [ffh_pkg::SEG_W-1:0]     size_o,
  output logic                          free_o
);

  logic                      hit_q, hit_d;
  logic [ffh_pkg::SEG_W-1:0] start_q, size_q;
  logic                      free_q;
  logic                      win;

  // The winner is the first cell of the prefix-OR run.
  assign win = at_i & ~left_at_i;

  always_comb begin
    case (match_i.mode)
      ffh_pkg::MODE_ALLOC:
        hit_d = valid_i & free_q & (ffh_pkg::NEED_W'(size_q) >= match_i.need);
      ffh_pkg::MODE_RELEASE:
        hit_d = valid_i & (ffh_pkg::ADDR_W'(start_q) == match_i.target);
      default:
        hit_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q   <= 1'b0;
      start_q <= '0;
      size_q  <= ffh_pkg::RESET_SEG_SIZE;
      free_q  <= 1'b1;
    end else begin
      if (match_i.en) begin
        hit_q <= hit_d;
      end
      if (upd_i.reinit) begin
        start_q <= '0;
        size_q  <= upd_i.init_size;
        free_q  <= 1'b1;
      end else if (upd_i.alloc) begin
        if (win) begin
          free_q <= 1'b0;
          if (upd_i.split) begin
            size_q <= upd_i.need;
          end
        end else if (upd_i.split && left_win_i) begin
          start_q <= upd_i.new_start;
          size_q  <= upd_i.new_size;
          free_q  <= 1'b1;
        end else if (upd_i.split && left_at_i) begin
          start_q <= left_start_i;
          size_q  <= left_size_i;
          free_q  <= left_free_i;
        end
      end else if (upd_i.release_seg && win) begin
        free_q <= 1'b1;
      end
    end
  end

  assign hit_o   = hit_q;
  assign win_o   = win;
  assign start_o = start_q;
  assign size_o  = size_q;
  assign free_o  = free_q;

endmodule

`default_nettype wire

>>> design/ffh_scan.sv
// ----------------------------------------------------------------------------
// First-fit heap allocator scan
// Two registered levels that turn the cell hit bits into a prefix-OR run
// marking the first hit and everything after it, plus the first hit's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module ffh_scan (
  input  wire logic                                           clk_i,
  input  wire logic                                           rst_ni,
  input  wire logic [ffh_pkg::MAX_SEGMENTS-1:0]               hit_i,
  input  wire logic [ffh_pkg::MAX_SEGMENTS-1:0][ffh_pkg::SEG_W-1:0] start_i,
  input  wire logic [ffh_pkg::MAX_SEGMENTS-1:0][ffh_pkg::SEG_W-1:0] size_i,
  output logic [ffh_pkg::MAX_SEGMENTS-1:0]                    at_o,
  output logic                                                any_o,
  output logic [ffh_pkg::SEG_W-1:0]                           win_start_o,
  output logic [ffh_pkg::SEG_W-1:0]                           win_size_o
);

  localparam int MAX  = ffh_pkg::MAX_SEGMENTS;
  localparam int GRP  = ffh_pkg::GRP_SIZE;
  localparam int NGRP = ffh_pkg::NUM_GRP;
  localparam int PAD  = ffh_pkg::PAD_W;
  localparam int SW   = ffh_pkg::SEG_W;

  logic [PAD-1:0]          hit_pad;
  logic [PAD-1:0][SW-1:0]  start_pad, size_pad;

  // Level one: per-group prefix and first-hit data.
  logic [MAX-1:0]          seen_d, seen_q;
  logic [NGRP-1:0]         grp_any_d, grp_any_q;
  logic [NGRP-1:0][SW-1:0] grp_start_d, grp_start_q, grp_size_d, grp_size_q;

  // Level two: global prefix and winner data.
  logic [NGRP-1:0]         earlier;
  logic [MAX-1:0]          at_d, at_q;
  logic                    any_d, any_q;
  logic [SW-1:0]           win_start_d, win_start_q, win_size_d, win_size_q;

  assign hit_pad = PAD'(hit_i);

  always_comb begin
    start_pad = '0;
    size_pad  = '0;
    for (int i = 0; i < MAX; i++) begin
      start_pad[i] = start_i[i];
      size_pad[i]  = size_i[i];
    end
  end

  always_comb begin
    logic [GRP-1:0] grp_hit;
    logic [GRP-1:0] below;
    logic           lead;
    seen_d      = '0;
    grp_any_d   = '0;
    grp_start_d = '0;
    grp_size_d  = '0;
    for (int g = 0; g < NGRP; g++) begin
      grp_hit      = hit_pad[g*GRP +: GRP];
      grp_any_d[g] = |grp_hit;
      for (int p = 0; p < GRP; p++) begin
        below = grp_hit & ((GRP'(1) << p) - GRP'(1));
        lead  = grp_hit[p] & ~(|below);
        if (g * GRP + p < MAX) begin
          seen_d[g*GRP + p] = grp_hit[p] | (|below);
        end
        if (lead) begin
          grp_start_d[g] = grp_start_d[g] | start_pad[g*GRP + p];
          grp_size_d[g]  = grp_size_d[g] | size_pad[g*GRP + p];
        end
      end
    end
  end

  always_comb begin
    at_d        = '0;
    win_start_d = '0;
    win_size_d  = '0;
    for (int g = 0; g < NGRP; g++) begin
      earlier[g] = |(grp_any_q & ((NGRP'(1) << g) - NGRP'(1)));
      if (grp_any_q[g] && !earlier[g]) begin
        win_start_d = win_start_d | grp_start_q[g];
        win_size_d  = win_size_d | grp_size_q[g];
      end
      for (int p = 0; p < GRP; p++) begin
        if (g * GRP + p < MAX) begin
          at_d[g*GRP + p] = earlier[g] | seen_q[g*GRP + p];
        end
      end
    end
    any_d = |grp_any_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q    <= '0;
      grp_any_q <= '0;
      at_q      <= '0;
      any_q     <= 1'b0;
    end else begin
      seen_q    <= seen_d;
      grp_any_q <= grp_any_d;
      at_q      <= at_d;
      any_q     <= any_d;
    end
  end

  always_ff @(posedge clk_i) begin
    grp_start_q <= grp_start_d;
    grp_size_q  <= grp_size_d;
    win_start_q <= win_start_d;
    win_size_q  <= win_size_d;
  end

  assign at_o        = at_q;
  assign any_o       = any_q;
  assign win_start_o = win_start_q;
  assign win_size_o  = win_size_q;

endmodule

`default_nettype wire

>>> design/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// First-fit heap allocator
// Address-ordered segment table with first-fit allocate, release and
// reinitialise, built as a row of table cells and a two-level scan.
// ----------------------------------------------------------------------------
// Each input word is one command: allocate, release or reinitialise. Every
// command returns exactly one result word holding an address and a status.
// A command passes through the states MATCH, GROUP, SELECT and APPLY before
// the next word can be accepted: in MATCH every cell compares its entry, in
// GROUP and SELECT the registered scan finds the first matching cell, and in
// APPLY the cells update (on a split, the cell after the winner takes the new
// free remainder and every later cell its left neighbor's entry, so the
// table shifts by one). The result is registered when the update fires, and
// the next word is taken while that result waits. The update cycle holds as
// long as an earlier result still sits stalled in the output register.
// After reset the table holds one free segment covering the heap minus one
// header, and the registers hold their reset values; no clearing pass runs.
// Configuration writes belong in idle periods only.
// ----------------------------------------------------------------------------
`default_nettype none

`include "first_fit_heap_allocator_macros.svh"

module first_fit_heap_allocator (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration write port.
  input  wire logic                          cfg_we_i,
  input  wire logic [ffh_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [ffh_pkg::CFG_DAT_W-1:0] cfg_data_i,
  // Command channel.
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    operation_i,
  input  wire logic [ffh_pkg::REQ_W-1:0]     request_bytes_i,
  input  wire logic [ffh_pkg::ADDR_W-1:0]    release_address_i,
  // Result channel.
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [ffh_pkg::ADDR_W-1:0]         address_o,
  output logic [ffh_pkg::STATUS_W-1:0]       status_o
);

  localparam int MAX   = ffh_pkg::MAX_SEGMENTS;
  localparam int CNT_W = ffh_pkg::CNT_W;
  localparam int SW    = ffh_pkg::SEG_W;
  localparam int NW    = ffh_pkg::NEED_W;
  localparam int AW    = ffh_pkg::ADDR_W;

  // Configuration registers.
  logic [AW-1:0]               heap_base_q;
  logic [ffh_pkg::HSIZE_W-1:0] heap_size_q;
  logic [ffh_pkg::HDR_W-1:0]   header_q;

  // Command registers, captured when a word is accepted.
  logic [1:0]                  op_raw_q;
  logic [NW-1:0]               need_q;
  logic [AW-1:0]               target_q;
  logic                        rel_null_q;

  ffh_pkg::ffh_state_e         state_q, state_d;
  logic [CNT_W-1:0]            count_q, count_d;
  logic                        accept, fire;

  logic                        out_valid_q;
  logic [AW-1:0]               address_q, address_d;
  ffh_pkg::ffh_status_e        status_q, status_d;

  // Cell row and scan wiring.
  logic [MAX-1:0]              seg_valid, hit, at, win;
  logic [MAX-1:0]              free, left_at, left_win, left_free;
  logic [MAX-1:0][SW-1:0]      start, size, left_start, left_size;
  logic                        any_hit;
  logic [SW-1:0]               win_start, win_size;

  ffh_pkg::ffh_match_t         match;
  ffh_pkg::ffh_upd_t           upd;

  logic [NW:0]                 split_limit;
  logic [ffh_pkg::HSIZE_W-1:0] total, init_diff;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q <= ffh_pkg::RESET_HEAP_BASE;
      heap_size_q <= ffh_pkg::RESET_HEAP_SIZE;
      header_q    <= ffh_pkg::RESET_HEADER;
    end else if (cfg_we_i) begin
      case (ffh_pkg::ffh_cfg_e'(cfg_index_i))
        ffh_pkg::CFG_HEAP_BASE:    heap_base_q <= cfg_data_i;
        ffh_pkg::CFG_HEAP_SIZE:    heap_size_q <= cfg_data_i[ffh_pkg::HSIZE_W-1:0];
        ffh_pkg::CFG_HEADER_BYTES: header_q    <= cfg_data_i[ffh_pkg::HDR_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign accept = (state_q == ffh_pkg::ST_IDLE) && in_valid_i;
  assign fire   = (state_q == ffh_pkg::ST_APPLY) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ffh_pkg::ST_IDLE:   if (in_valid_i) state_d = ffh_pkg::ST_MATCH;
      ffh_pkg::ST_MATCH:  state_d = ffh_pkg::ST_GROUP;
      ffh_pkg::ST_GROUP:  state_d = ffh_pkg::ST_SELECT;
      ffh_pkg::ST_SELECT: state_d = ffh_pkg::ST_APPLY;
      ffh_pkg::ST_APPLY:  if (fire) state_d = ffh_pkg::ST_IDLE;
      default:            state_d = ffh_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != ffh_pkg::ST_IDLE);
    match.en   = (state_q == ffh_pkg::ST_MATCH);
    match.need = need_q;
    match.target = target_q;
    // A null release, a reinitialise and the unused code match nothing.
    case (op_raw_q)
      ffh_pkg::OP_ALLOC:   match.mode = ffh_pkg::MODE_ALLOC;
      ffh_pkg::OP_RELEASE: match.mode = rel_null_q ? ffh_pkg::MODE_NONE
                                                   : ffh_pkg::MODE_RELEASE;
      default:             match.mode = ffh_pkg::MODE_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffh_pkg::ST_IDLE;
      count_q <= CNT_W'(1);
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Command capture: the request is rounded up to a multiple of four, and
  // the release address is turned into a header offset once so that every
  // cell only needs an equality compare.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_raw_q   <= operation_i;
      need_q     <= (NW'(request_bytes_i) + NW'(3)) & ~NW'(3);
      target_q   <= release_address_i - heap_base_q - AW'(header_q);
      rel_null_q <= (release_address_i == '0);
    end
  end

  // --------------------------------------------------------------------------
  // Update broadcast
  // --------------------------------------------------------------------------
  // A split needs room for one more header past the request and a free slot
  // at the end of the table.
  assign split_limit = (NW + 1)'(need_q) + (NW + 1)'(header_q);
  assign total       = (heap_size_q > ffh_pkg::HEAP_LIMIT) ? ffh_pkg::HEAP_LIMIT
                                                          : heap_size_q;
  assign init_diff   = total - ffh_pkg::HSIZE_W'(header_q);

  always_comb begin
    upd.alloc       = fire && (op_raw_q == ffh_pkg::OP_ALLOC);
    upd.release_seg = fire && (op_raw_q == ffh_pkg::OP_RELEASE);
    upd.reinit      = fire && (op_raw_q == ffh_pkg::OP_REINIT);
    upd.split       = ((NW + 1)'(win_size) > split_limit) && (count_q != CNT_W'(MAX));
    upd.need        = need_q[SW-1:0];
    upd.new_start   = win_start + SW'(header_q) + need_q[SW-1:0];
    upd.new_size    = win_size - need_q[SW-1:0] - SW'(header_q);
    upd.init_size   = (total > ffh_pkg::HSIZE_W'(header_q)) ? init_diff[SW-1:0] : '0;
  end

  always_comb begin
    count_d = count_q;
    if (upd.reinit) begin
      count_d = CNT_W'(1);
    end else if (upd.alloc && any_hit && upd.split) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Result
  // --------------------------------------------------------------------------
  always_comb begin
    address_d = '0;
    case (op_raw_q)
      ffh_pkg::OP_ALLOC: begin
        if (any_hit) begin
          status_d  = ffh_pkg::STS_GRANTED;
          address_d = heap_base_q + AW'(win_start) + AW'(header_q);
        end else begin
          status_d  = ffh_pkg::STS_NO_MEM;
        end
      end
      ffh_pkg::OP_RELEASE: begin
        if (rel_null_q) status_d = ffh_pkg::STS_IGNORED;
        else if (any_hit) status_d = ffh_pkg::STS_RELEASED;
        else status_d = ffh_pkg::STS_UNKNOWN;
      end
      ffh_pkg::OP_REINIT: status_d = ffh_pkg::STS_GRANTED;
      default:            status_d = ffh_pkg::STS_IGNORED;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      address_q <= address_d;
      status_q  <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign address_o   = address_q;
  assign status_o    = status_q;

  // --------------------------------------------------------------------------
  // Cell row
  // --------------------------------------------------------------------------
  // Valid entries always form a prefix of the row, so the count decides them.
  always_comb begin
    for (int k = 0; k < MAX; k++) begin
      seg_valid[k] = (count_q > CNT_W'(k));
      if (k == 0) begin
        left_at[k]    = 1'b0;
        left_win[k]   = 1'b0;
        left_free[k]  = 1'b0;
        left_start[k] = '0;
        left_size[k]  = '0;
      end else begin
        left_at[k]    = at[k-1];
        left_win[k]   = win[k-1];
        left_free[k]  = free[k-1];
        left_start[k] = start[k-1];
        left_size[k]  = size[k-1];
      end
    end
  end

  for (genvar k = 0; k < MAX; k++) begin : g_cell
    ffh_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .valid_i      (seg_valid[k]),
      .match_i      (match),
      .upd_i        (upd),
      .at_i         (at[k]),
      .left_at_i    (left_at[k]),
      .left_win_i   (left_win[k]),
      .left_start_i (left_start[k]),
      .left_size_i  (left_size[k]),
      .left_free_i  (left_free[k]),
      .hit_o        (hit[k]),
      .win_o        (win[k]),
      .start_o      (start[k]),
      .size_o       (size[k]),
      .free_o       (free[k])
    );
  end

  ffh_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hit_i       (hit),
    .start_i     (start),
    .size_i      (size),
    .at_o        (at),
    .any_o       (any_hit),
    .win_start_o (win_start),
    .win_size_o  (win_size)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `FFH_ASSERT(a_count_range, (count_q != '0) && (count_q <= CNT_W'(MAX)), "segment count out of range")
  `FFH_ASSERT_IMP(a_one_winner, state_q == ffh_pkg::ST_APPLY, $onehot0(win), "more than one winning cell")
  `FFH_ASSERT_IMP(a_winner_any, state_q == ffh_pkg::ST_APPLY, (|win) == any_hit, "winner and scan disagree")
  `FFH_ASSERT(a_split_grows, (upd.alloc && any_hit && upd.split) |=> (count_q == $past(count_q) + CNT_W'(1)), "split did not grow the table")
  `FFH_ASSERT(a_apply_holds, (state_q == ffh_pkg::ST_APPLY && out_valid_q && out_stall_i) |=> (state_q == ffh_pkg::ST_APPLY), "update ran over a stalled result")

endmodule

`default_nettype wire

>>> tb/first_fit_heap_allocator_checker.sv
// ----------------------------------------------------------------------------
// First-fit heap allocator checker
// Follows every accepted command word and register write, predicts each
// result word from a private copy of the segment table, and compares the
// result words that come out of the allocator in order.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ffh_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ffh_pkg::CFG_DAT_W-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [1:0]                    operation_i,
  input  logic [ffh_pkg::REQ_W-1:0]     request_bytes_i,
  input  logic [ffh_pkg::ADDR_W-1:0]    release_address_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [ffh_pkg::ADDR_W-1:0]    address_i,
  input  logic [ffh_pkg::STATUS_W-1:0]  status_i,
  output int                            error_count_o,
  output int                            pending_o
);
  import ffh_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    ffh_status_e       status;
  } reply_t;

  // Register copies.
  logic [ADDR_W-1:0]  base_addr;
  logic [HSIZE_W-1:0] span_bytes;
  logic [HDR_W-1:0]   hdr_len;

  // Segment table copy, kept in address order.
  logic [SEG_W-1:0] seg_off   [MAX_SEGMENTS];
  logic [SEG_W-1:0] seg_len   [MAX_SEGMENTS];
  logic             seg_avail [MAX_SEGMENTS];
  int               seg_total;

  reply_t replies_due[$];
  int     mismatches = 0;

  // One free segment covering the heap, less one header.
  function automatic void restart_table();
    logic [31:0] total;
    logic [31:0] left;
    logic [31:0] hdr;
    total = 32'(span_bytes);
    hdr   = 32'(hdr_len);
    if (total > 32'h100_0000) total = 32'h100_0000;
    left = total - hdr;
    seg_off[0]   = '0;
    seg_len[0]   = (total > hdr) ? left[SEG_W-1:0] : '0;
    seg_avail[0] = 1'b1;
    seg_total    = 1;
  endfunction

  function automatic reply_t run_command(logic [1:0] op, logic [REQ_W-1:0] req,
                                         logic [ADDR_W-1:0] rel);
    reply_t      r;
    logic [31:0] need;
    logic [31:0] room;
    logic [31:0] hdr;
    logic [31:0] tail;
    int          i;
    int          j;
    bit          hit;
    r.address = '0;
    r.status  = STS_IGNORED;
    hdr       = 32'(hdr_len);
    hit       = 1'b0;
    case (op)
      OP_ALLOC: begin
        need     = 32'(req);
        need     = (need + 32'd3) & 32'hFFFF_FFFC;
        r.status = STS_NO_MEM;
        for (i = 0; i < seg_total && !hit; i++) begin
          room = 32'(seg_len[i]);
          if (seg_avail[i] && room >= need) begin
            // The remainder becomes a new free segment only when it can hold
            // a header of its own and the table still has a free row.
            if (room > need + hdr && seg_total < MAX_SEGMENTS) begin
              for (j = seg_total; j > i + 1; j--) begin
                seg_off[j]   = seg_off[j-1];
                seg_len[j]   = seg_len[j-1];
                seg_avail[j] = seg_avail[j-1];
              end
              tail           = 32'(seg_off[i]) + hdr + need;
              seg_off[i+1]   = tail[SEG_W-1:0];
              tail           = room - need - hdr;
              seg_len[i+1]   = tail[SEG_W-1:0];
              seg_avail[i+1] = 1'b1;
              seg_len[i]     = need[SEG_W-1:0];
              seg_total++;
            end
            seg_avail[i] = 1'b0;
            r.address    = base_addr + 32'(seg_off[i]) + hdr;
            r.status     = STS_GRANTED;
            hit          = 1'b1;
          end
        end
      end
      OP_RELEASE: begin
        if (rel != '0) begin
          r.status = STS_UNKNOWN;
          for (i = 0; i < seg_total && !hit; i++) begin
            if (base_addr + 32'(seg_off[i]) + hdr == rel) begin
              seg_avail[i] = 1'b1;
              r.status     = STS_RELEASED;
              hit          = 1'b1;
            end
          end
        end
      end
      OP_REINIT: begin
        restart_table();
        r.status = STS_GRANTED;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    reply_t want;
    if (!rst_ni) begin
      base_addr  = RESET_HEAP_BASE;
      span_bytes = RESET_HEAP_SIZE;
      hdr_len    = RESET_HEADER;
      restart_table();
      replies_due.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_HEAP_BASE:    base_addr  = cfg_data_i;
          CFG_HEAP_SIZE:    span_bytes = cfg_data_i[HSIZE_W-1:0];
          CFG_HEADER_BYTES: hdr_len    = cfg_data_i[HDR_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (replies_due.size() == 0) begin
          $display("%0t: result word with none awaited, address %h status %0d",
                   $time, address_i, status_i);
          mismatches++;
        end else begin
          want = replies_due.pop_front();
          if (address_i !== want.address) begin
            $display("%0t: address mismatch, expected %h, actual %h",
                     $time, want.address, address_i);
            mismatches++;
          end
          if (status_i !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, status_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        replies_due.push_back(run_command(operation_i, request_bytes_i,
                                          release_address_i));
    end
    error_count_o <= mismatches;
    pending_o     <= replies_due.size();
  end

endmodule

>>> tb/first_fit_heap_allocator_tb.sv
// ----------------------------------------------------------------------------
// First-fit heap allocator testbench
// Drives command words and register writes into the allocator, with random
// idle bursts on both channels, while a checker beside it predicts and
// compares every result word. A directed opening covers the corner cases;
// random sessions of allocate and release then fill, fragment and reuse the
// segment table under changing heap settings.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_tb;
  import ffh_pkg::*;

  // Command words issued in the random part, noise words included.
  localparam int RANDOM_ITEMS = 1550;
  // From this count on, neither side idles.
  localparam int QUIET_FROM   = RANDOM_ITEMS - 150;
  // Cycles without any handshake before the run is declared hung.
  localparam int IDLE_LIMIT   = 2000;
  // The one operation code the allocator does not define.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic                 clk_i             = 1'b0;
  logic                 rst_ni            = 1'b0;
  logic                 cfg_we_i          = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i       = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i        = '0;
  logic                 in_valid_i        = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           operation_i       = '0;
  logic [REQ_W-1:0]     request_bytes_i   = '0;
  logic [ADDR_W-1:0]    release_address_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i       = 1'b0;
  logic [ADDR_W-1:0]    address_o;
  logic [STATUS_W-1:0]  status_o;

  int errors;
  int pending;
  // Idle odds: one chance in N per word or cycle; zero switches idling off.
  int gap_odds    = 0;
  int stall_odds  = 0;
  int counted     = 0;
  int idle_cycles = 0;
  // Heap size last programmed, used to scale random requests.
  logic [HSIZE_W-1:0] heap_span = RESET_HEAP_SIZE;
  // Payload addresses granted so far, the pool that releases draw from.
  logic [ADDR_W-1:0] live_blocks[$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  first_fit_heap_allocator DUT (.*);

  first_fit_heap_allocator_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .operation_i      (operation_i),
    .request_bytes_i  (request_bytes_i),
    .release_address_i(release_address_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .address_i        (address_o),
    .status_i         (status_o),
    .error_count_o    (errors),
    .pending_o        (pending)
  );

  // The result side stalls in bursts of random length, and each burst is
  // followed by open time before the next one can start.
  initial begin : result_stalls
    forever begin
      @(posedge clk_i);
      if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Every granted nonzero address goes into the pool, so that later releases
  // hit live segments. A reinitialise also reports status zero, but with a
  // zero address, and is left out.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i && status_o == STS_GRANTED && address_o != '0)
      live_blocks.push_back(address_o);
  end

  // Hang detection: any handshake or register write restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) ||
        (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offers one command word, after an optional idle burst, and returns at
  // the edge where it is taken. Valid stays high on return so that a word
  // that follows at once does not see valid dropped and raised in one step.
  task automatic issue(input logic [1:0] op, input logic [REQ_W-1:0] req,
                       input logic [ADDR_W-1:0] rel);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    operation_i       <= op;
    request_bytes_i   <= req;
    release_address_i <= rel;
    do @(posedge clk_i); while (in_stall_o);
    counted++;
  endtask

  // Stops offering words and waits until every awaited result word is in.
  // The checker's count is registered, so the loop waits on an edge before it looks.
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Writes all three registers on back-to-back edges. Only called after
  // settle(), while the allocator is idle.
  task automatic program_heap(input logic [31:0] base, input logic [31:0] span,
                              input logic [31:0] hdr);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_HEAP_BASE;
    cfg_data_i  <= base;
    @(posedge clk_i);
    cfg_index_i <= CFG_HEAP_SIZE;
    cfg_data_i  <= span;
    @(posedge clk_i);
    cfg_index_i <= CFG_HEADER_BYTES;
    cfg_data_i  <= hdr;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    heap_span = span[HSIZE_W-1:0];
  endtask

  initial begin : stimulus
    int               n;
    int               k;
    int               roll;
    int               phase;
    int               burst_len;
    bit               fill;
    logic [31:0]      base;
    logic [31:0]      span;
    logic [31:0]      hdr;
    logic [ADDR_W-1:0] rel;
    logic [REQ_W-1:0] req;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- Directed part ----
    gap_odds   = 3;
    stall_odds = 3;
    // Reset values: heap at 0x100000, 1 MiB, 12-byte headers, one free
    // segment. A zero request still takes the first free segment and splits.
    issue(OP_ALLOC, '0, '0);
    issue(OP_ALLOC, 25'd1, '0);
    issue(OP_ALLOC, 25'd5, '0);
    // Release the first payload twice; the second release finds it already
    // free and still reports it released.
    issue(OP_RELEASE, '0, 32'h0010_000C);
    issue(OP_RELEASE, '0, 32'h0010_000C);
    issue(OP_RELEASE, '0, '0);
    issue(OP_RELEASE, 25'h1FF_FFFF, 32'hFFFF_FFFF);
    issue(OP_UNUSED, 25'h1FF_FFFF, 32'hFFFF_FFFF);
    // Requests larger than any heap.
    issue(OP_ALLOC, 25'h1FF_FFFF, '0);
    issue(OP_ALLOC, 25'h100_0000, '0);
    // The freed zero-size segment is first in line again.
    issue(OP_ALLOC, '0, '0);
    issue(OP_REINIT, '0, '0);

    // Smallest heap, placed so that the first payload sits at address zero:
    // releasing zero must still be taken as null. The second grant wraps.
    settle();
    program_heap(32'hFFFF_FFF4, 32'd64, 32'd12);
    issue(OP_REINIT, '0, '0);
    issue(OP_ALLOC, '0, '0);
    issue(OP_RELEASE, '0, '0);
    issue(OP_ALLOC, 25'd40, '0);
    issue(OP_ALLOC, '0, '0);

    // Heap no larger than one header: the single segment has no payload.
    settle();
    program_heap(32'h0000_0000, 32'd64, 32'd64);
    issue(OP_REINIT, '0, '0);
    issue(OP_ALLOC, '0, '0);
    issue(OP_ALLOC, '0, '0);

    // Heap size above the 16 MiB limit is clipped to it; top base address.
    settle();
    program_heap(32'hFFFF_FFFF, 32'h01FF_FFFF, 32'd4);
    issue(OP_REINIT, '0, '0);
    issue(OP_ALLOC, 25'hFF_FFFC, '0);
    issue(OP_REINIT, '0, '0);
    issue(OP_ALLOC, 25'hFF_FFFD, '0);

    // ---- Random sessions ----
    // Each session settles, picks new heap settings, mostly reinitialises,
    // and then runs a mix of allocates and releases of live blocks, with a
    // little noise. Every fifth session is a fill session: tiny requests
    // that push the table up to its last row, so that later grants take
    // whole segments without splitting.
    counted = 0;
    phase   = 0;
    while (counted < RANDOM_ITEMS) begin
      fill = (phase % 5 == 1);
      settle();
      case ($urandom_range(0, 5))
        0:       base = 32'h0000_0000;
        1:       base = 32'hFFFF_FFFF - $urandom_range(0, 255);
        default: base = $urandom;
      endcase
      case ($urandom_range(0, 7))
        0:       span = 32'd64;
        1:       span = 32'h100_0000;
        2:       span = $urandom_range(32'h100_0001, 32'h1FF_FFFF);
        3, 4:    span = $urandom_range(64, 1024);
        5:       span = $urandom_range(1025, 65536);
        default: span = $urandom_range(65537, 32'h100_0000);
      endcase
      case ($urandom_range(0, 3))
        0:       hdr = 32'd4;
        1:       hdr = 32'd64;
        default: hdr = $urandom_range(4, 64);
      endcase
      if (fill) span = $urandom_range(32'h4_0000, 32'h100_0000);
      program_heap(base, span, hdr);

      if (counted < QUIET_FROM) begin
        case ($urandom_range(0, 2))
          0:       gap_odds = 0;
          1:       gap_odds = 2;
          default: gap_odds = 6;
        endcase
        case ($urandom_range(0, 2))
          0:       stall_odds = 0;
          1:       stall_odds = 2;
          default: stall_odds = 6;
        endcase
      end

      // Sometimes the table is kept across new settings, so that old
      // segments are addressed with the new base and header size.
      if (fill || $urandom_range(0, 3) != 0) begin
        issue(OP_REINIT, REQ_W'($urandom), $urandom);
        live_blocks.delete();
      end

      burst_len = fill ? 360 : $urandom_range(20, 80);
      for (n = 0; n < burst_len && counted < RANDOM_ITEMS; n++) begin
        if (counted >= QUIET_FROM) begin
          gap_odds   = 0;
          stall_odds = 0;
        end
        roll = $urandom_range(0, 99);
        if (fill && roll < 85) roll = 0;
        if (roll < 50 || (roll < 80 && live_blocks.size() == 0)) begin
          case ($urandom_range(0, 9))
            0:       req = REQ_W'($urandom);
            1, 2:    req = REQ_W'($urandom_range(0, heap_span));
            default: req = REQ_W'($urandom_range(0, 64));
          endcase
          if (fill) req = REQ_W'($urandom_range(0, 16));
          issue(OP_ALLOC, req, $urandom);
        end else if (roll < 80) begin
          k   = $urandom_range(0, live_blocks.size() - 1);
          rel = live_blocks[k];
          // Most blocks leave the pool once released; a few stay behind and
          // get released a second time later.
          if ($urandom_range(0, 4) != 0) live_blocks.delete(k);
          issue(OP_RELEASE, REQ_W'($urandom), rel);
        end else if (roll < 88) begin
          case ($urandom_range(0, 2))
            0:       rel = '0;
            1:       rel = $urandom;
            default: rel = base + hdr + $urandom_range(0, 64);
          endcase
          issue(OP_RELEASE, REQ_W'($urandom), rel);
        end else if (roll < 94) begin
          issue(OP_UNUSED, REQ_W'($urandom), $urandom);
        end else if (roll < 97) begin
          issue(OP_REINIT, REQ_W'($urandom), $urandom);
          live_blocks.delete();
        end else begin
          // Let the allocator run dry before going on.
          settle();
        end
      end
      phase++;
    end

    // Wait for the last result word, then a while longer so that any extra
    // word shows up in the checker before the verdict.
    settle();
    repeat (12) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
